// File: rtl/core/ntmt_pkg.sv
`default_nettype none
package ntmt_pkg;

  typedef enum logic [3:0] {
    K_CREATE   = 4'd0,
    K_GET64    = 4'd1,
    K_GET16    = 4'd2,
    K_GET_TO   = 4'd3,
    K_DEL64    = 4'd4,
    K_DEL16    = 4'd5,
    K_DEL_SLOT = 4'd6,
    K_TICK     = 4'd7,
    K_FLUSH    = 4'd8,
    K_WRITE    = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONEXT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_ACT,
    S_SHIFT,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    M_LONG,
    M_SHORT,
    M_TTL,
    M_SLOT
  } match_t;

  localparam logic [15:0] SHORT_UNSET = 16'hFFFF;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic free_step;
    logic act;
    logic shift_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic free_done;
    logic shift_done;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/ntmt_ctrl.sv
`default_nettype none
module ntmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [3:0]    in_kind,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire ntmt_pkg::sts_t sts,
  output ntmt_pkg::cmd_t     cmd
);

  ntmt_pkg::state_t state_r, state_nxt;
  logic [3:0] kind_r, kind_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntmt_pkg::S_IDLE;
      kind_r  <= 4'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ov_nxt    = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      ntmt_pkg::S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_kind;
          state_nxt = ntmt_pkg::S_SCAN;
        end
      end
      ntmt_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          if (kind_r == ntmt_pkg::K_CREATE && !sts.hit) state_nxt = ntmt_pkg::S_FREE;
          else state_nxt = ntmt_pkg::S_ACT;
        end
      end
      ntmt_pkg::S_FREE:  if (sts.free_done) state_nxt = ntmt_pkg::S_ACT;
      ntmt_pkg::S_ACT:   state_nxt = ntmt_pkg::S_SHIFT;
      ntmt_pkg::S_SHIFT: if (sts.shift_done) state_nxt = ntmt_pkg::S_OUT;
      ntmt_pkg::S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          state_nxt = ntmt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ntmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = (state_r == ntmt_pkg::S_IDLE);
    out_tvalid = ov_r;
    case (state_r)
      ntmt_pkg::S_IDLE:  cmd.start = in_tvalid;
      ntmt_pkg::S_SCAN:  cmd.scan_step = 1'b1;
      ntmt_pkg::S_FREE:  cmd.free_step = 1'b1;
      ntmt_pkg::S_ACT:   cmd.act = 1'b1;
      ntmt_pkg::S_SHIFT: cmd.shift_step = 1'b1;
      ntmt_pkg::S_OUT:   cmd.out_load = !ov_r || out_tready;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ntmt_dp.sv
`default_nettype none
module ntmt_dp #(
  parameter int ENTRIES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [143:0]  in_tdata,
  input  wire logic [3:0]    in_kind,
  input  wire logic [7:0]    reload,
  input  wire ntmt_pkg::cmd_t cmd,
  output ntmt_pkg::sts_t     sts,
  output logic [119:0]       out_tdata
);

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [3:0]  kind_r;
  logic [63:0] a64_r;
  logic [15:0] a16_r, ticks_r, nttl_r, nshort_r;
  logic [3:0]  slot_r;
  logic [7:0]  nlink_r;

  logic          valid_r [ENTRIES];
  logic [63:0]   la_r    [ENTRIES];
  logic [15:0]   sa_r    [ENTRIES];
  logic [15:0]   ttl_r   [ENTRIES];
  logic [7:0]    lc_r    [ENTRIES];
  logic [SW-1:0] ord_r   [ENTRIES];
  logic [CW-1:0] used_r;

  logic [CW-1:0] p_r;
  logic [CW-1:0] q_r;
  logic          hit_r;
  logic          front_r;
  logic [4:0]    cnt_r;
  logic [1:0]    st_r;
  logic [SW-1:0] es_r;
  logic          ent_r;

  logic [SW-1:0] cur;
  logic [SW-1:0] slot_ix;
  logic          match, slot_ok;

  assign cur = ord_r[p_r[SW-1:0]];
  assign slot_ix = SW'(slot_r);
  assign slot_ok = ({28'd0, slot_r} < 32'(ENTRIES)) && valid_r[slot_ix];

  always_comb begin
    case (kind_r)
      ntmt_pkg::K_CREATE, ntmt_pkg::K_GET64, ntmt_pkg::K_DEL64: match = la_r[cur] == a64_r;
      ntmt_pkg::K_GET16, ntmt_pkg::K_DEL16: match = sa_r[cur] == a16_r;
      ntmt_pkg::K_GET_TO: match = ttl_r[cur] == 16'd0;
      ntmt_pkg::K_DEL_SLOT: match = cur == slot_ix;
      default: match = 1'b0;
    endcase
  end

  logic scan_kind;
  assign scan_kind = kind_r == ntmt_pkg::K_CREATE || kind_r == ntmt_pkg::K_GET64 ||
                     kind_r == ntmt_pkg::K_GET16 || kind_r == ntmt_pkg::K_GET_TO ||
                     kind_r == ntmt_pkg::K_DEL64 || kind_r == ntmt_pkg::K_DEL16 ||
                     (kind_r == ntmt_pkg::K_DEL_SLOT && slot_ok) ||
                     kind_r == ntmt_pkg::K_TICK;

  assign sts.scan_done  = !scan_kind || hit_r || p_r >= used_r;
  assign sts.hit        = hit_r;
  assign sts.free_done  = !valid_r[p_r[SW-1:0]] || p_r >= CW'(ENTRIES) || used_r >= CW'(ENTRIES);
  assign sts.shift_done = q_r == 0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
      used_r <= '0;
    end else begin
      if (cmd.start) begin
        kind_r <= in_kind; a64_r <= in_tdata[63:0]; a16_r <= in_tdata[79:64];
        slot_r <= in_tdata[83:80]; ticks_r <= in_tdata[99:84];
        nttl_r <= in_tdata[115:100]; nshort_r <= in_tdata[131:116];
        nlink_r <= in_tdata[139:132];
        p_r <= '0; hit_r <= 1'b0; cnt_r <= '0; q_r <= '0; front_r <= 1'b0;
      end
      if (cmd.scan_step && !sts.scan_done) begin
        if (kind_r == ntmt_pkg::K_TICK) begin
          if (ttl_r[cur] > ticks_r) ttl_r[cur] <= ttl_r[cur] - ticks_r;
          else begin
            if (ttl_r[cur] != 16'd0) begin
              lc_r[cur] <= reload; ttl_r[cur] <= 16'd0;
            end
            if (cnt_r != ntmt_pkg::COUNT_MAX) cnt_r <= cnt_r + 5'd1;
          end
          p_r <= p_r + 1'b1;
        end else if (match) hit_r <= 1'b1;
        else p_r <= p_r + 1'b1;
      end
      if (cmd.scan_step && sts.scan_done && kind_r == ntmt_pkg::K_CREATE && !hit_r)
        p_r <= '0;
      if (cmd.free_step && !sts.free_done) p_r <= p_r + 1'b1;
      if (cmd.act) begin
        case (kind_r)
          ntmt_pkg::K_CREATE: begin
            if (hit_r) begin
              st_r <= ntmt_pkg::ST_OK; es_r <= cur; ent_r <= 1'b1;
              q_r <= p_r; front_r <= 1'b1;
            end else if (used_r >= CW'(ENTRIES) || p_r >= CW'(ENTRIES)) begin
              st_r <= ntmt_pkg::ST_FULL; ent_r <= 1'b0;
            end else begin
              valid_r[p_r[SW-1:0]] <= 1'b1; la_r[p_r[SW-1:0]] <= a64_r;
              sa_r[p_r[SW-1:0]] <= ntmt_pkg::SHORT_UNSET;
              ttl_r[p_r[SW-1:0]] <= '0; lc_r[p_r[SW-1:0]] <= '0;
              ord_r[used_r[SW-1:0]] <= p_r[SW-1:0];
              used_r <= used_r + 1'b1;
              q_r <= used_r; front_r <= 1'b1;
              st_r <= ntmt_pkg::ST_OK; es_r <= p_r[SW-1:0]; ent_r <= 1'b1;
            end
          end
          ntmt_pkg::K_GET64, ntmt_pkg::K_GET16, ntmt_pkg::K_GET_TO: begin
            if (hit_r) begin
              st_r <= ntmt_pkg::ST_OK; es_r <= cur; ent_r <= 1'b1;
              q_r <= p_r; front_r <= 1'b1;
            end else begin
              st_r <= ntmt_pkg::ST_NOTFOUND; ent_r <= 1'b0;
            end
          end
          ntmt_pkg::K_DEL64, ntmt_pkg::K_DEL16: begin
            if (hit_r) begin
              st_r <= ntmt_pkg::ST_OK; es_r <= cur; ent_r <= 1'b1;
              valid_r[cur] <= 1'b0; used_r <= used_r - 1'b1;
              q_r <= used_r - 1'b1 - p_r;
            end else begin
              st_r <= ntmt_pkg::ST_NOTFOUND; ent_r <= 1'b0;
            end
          end
          ntmt_pkg::K_DEL_SLOT: begin
            if (hit_r) begin
              valid_r[cur] <= 1'b0; used_r <= used_r - 1'b1;
              q_r <= used_r - 1'b1 - p_r;
              es_r <= ord_r[p_r[SW-1:0] + 1'b1];
              ent_r <= (p_r + 1'b1 < used_r);
              st_r <= (p_r + 1'b1 < used_r) ? ntmt_pkg::ST_OK : ntmt_pkg::ST_NONEXT;
            end else begin
              st_r <= ntmt_pkg::ST_NOTFOUND; ent_r <= 1'b0;
            end
          end
          ntmt_pkg::K_TICK: begin
            st_r <= ntmt_pkg::ST_OK; ent_r <= 1'b0;
          end
          ntmt_pkg::K_FLUSH: begin
            for (int i = 0; i < ENTRIES; i++) valid_r[i] <= 1'b0;
            used_r <= '0; st_r <= ntmt_pkg::ST_OK; ent_r <= 1'b0;
            cnt_r <= (used_r > CW'(ntmt_pkg::COUNT_MAX)) ? ntmt_pkg::COUNT_MAX : 5'(used_r);
          end
          ntmt_pkg::K_WRITE: begin
            if (slot_ok) begin
              ttl_r[slot_ix] <= nttl_r; sa_r[slot_ix] <= nshort_r;
              lc_r[slot_ix] <= nlink_r;
              st_r <= ntmt_pkg::ST_OK; es_r <= slot_ix; ent_r <= 1'b1;
            end else begin
              st_r <= ntmt_pkg::ST_NOTFOUND; ent_r <= 1'b0;
            end
          end
          default: begin
            st_r <= ntmt_pkg::ST_NOTFOUND; ent_r <= 1'b0;
          end
        endcase
      end
      if (cmd.shift_step && q_r != 0) begin
        if (front_r) begin
          ord_r[q_r[SW-1:0]] <= ord_r[q_r[SW-1:0] - 1'b1];
          ord_r[q_r[SW-1:0] - 1'b1] <= ord_r[q_r[SW-1:0]];
        end else begin
          ord_r[p_r[SW-1:0]] <= ord_r[p_r[SW-1:0] + 1'b1];
          p_r <= p_r + 1'b1;
        end
        q_r <= q_r - 1'b1;
      end
    end
  end

  logic [SW-1:0] os;
  assign os = es_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= {5'd0, cnt_r,
                    ent_r ? {lc_r[os], ttl_r[os], sa_r[os], la_r[os], 4'(os)} : 108'd0,
                    st_r};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/neighbor_table_mru_ttl.sv
// Channel | Direction | Content
// in_     | input     | tuser: kind; tdata: addr64..new_link_count
// out_    | output    | tdata: status..count
// cfg_    | APB       | link_request_reload at address 0
// An item passes through a scan of the order list at one entry per cycle, the
// free-slot search of a new entry and the order shift at one step per cycle.
// Reset is synchronous and active low; it empties the table.
// A finished result waits in the output register; the next item is taken first.
`default_nettype none
module neighbor_table_mru_ttl #(
  parameter int ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // addr64, addr16, slot_in, ticks, new_ttl, new_short_addr, new_link_count
  input  wire logic [143:0] in_tdata,
  // kind
  input  wire logic [3:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status, slot_out, entry_long_addr, entry_short_addr, entry_ttl,
  // entry_link_count, count
  output logic [119:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [1:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [7:0] reload_r;
  ntmt_pkg::cmd_t cmd;
  ntmt_pkg::sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {24'd0, reload_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) reload_r <= 8'd3;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      reload_r <= cfg_pwdata[7:0];
  end

  ntmt_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_kind(in_tuser),
    .out_tvalid, .out_tready, .sts, .cmd
  );

  ntmt_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk, .rst_n, .in_tdata, .in_kind(in_tuser), .reload(reload_r),
    .cmd, .sts, .out_tdata
  );

endmodule
`default_nettype wire
